// ===== rtl/core/block_fir_filter_zero_padded_macros.svh =====
// Assertion macros shared by the block_fir_filter_zero_padded RTL.
// No dependencies; the bodies collapse to nothing when SYNTHESIS is defined.
`ifndef BLOCK_FIR_FILTER_ZERO_PADDED_MACROS_SVH
`define BLOCK_FIR_FILTER_ZERO_PADDED_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define FZP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define FZP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define FZP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FZP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/fir_zp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the zero-padded block FIR filter.
// No dependencies; used by fir_zp_mac and block_fir_filter_zero_padded.
package fir_zp_pkg;

   localparam int TAPS       = 32;
   localparam int HALF_TAPS  = TAPS / 2;
   localparam int DELAY      = TAPS - HALF_TAPS;

   localparam int SAMPLE_W   = 12;
   localparam int COEFF_W    = 16;
   localparam int IDX_W      = 7;
   localparam int OUT_W      = 16;
   localparam int FRAC_BITS  = 15;

   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = SAMPLE_W / DIGIT_W;
   localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FILL_W     = $clog2(DELAY + 1);

   localparam int CW_W       = COEFF_W + SAMPLE_W - DIGIT_W;
   localparam int PROD_W     = CW_W + DIGIT_W + 1;
   localparam int ACC_W      = COEFF_W + SAMPLE_W + 1 + TAP_W;
   localparam int Q_W        = ACC_W - FRAC_BITS;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_COEFF  = 1'b1;

   typedef struct packed {
      logic en;
      logic load_tap;
      logic clear_acc;
      logic round;
   } mac_ctrl_type;

endpackage

// ===== rtl/core/fir_zp_mac.sv =====
`timescale 1ns / 1ps
// Digit-serial multiply-accumulate unit with rounding toward zero and saturation.
// Depends on fir_zp_pkg.
module fir_zp_mac (
   input  logic                                 clock,
   input  fir_zp_pkg::mac_ctrl_type             ctrl,
   input  logic signed [fir_zp_pkg::COEFF_W-1:0] coeff,
   input  logic [fir_zp_pkg::SAMPLE_W-1:0]      sample,
   output logic signed [fir_zp_pkg::OUT_W-1:0]  result
);
   import fir_zp_pkg::*;

   localparam int ROUND_BIAS = (1 << FRAC_BITS) - 1;
   localparam logic signed [Q_W-1:0]   Q_MAX   = Q_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [Q_W-1:0]   Q_MIN   = Q_W'(-(1 << (OUT_W - 1)));
   localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(-(1 << (OUT_W - 1)));

   logic signed [CW_W-1:0]   cw_ff, cw_in, cw_cur;
   logic [SAMPLE_W-1:0]      sh_ff, sh_in, sh_src;
   logic [DIGIT_W-1:0]       digit;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_base, adj;
   logic signed [Q_W-1:0]    q_ff, q_in;

   // The coefficient is pre-shifted by one digit weight per cycle while the unit is enabled, so each
   // product lines up with the accumulator without a variable shifter.
   always_comb begin
      cw_cur   = ctrl.load_tap ? CW_W'(coeff) : cw_ff;
      sh_src   = ctrl.load_tap ? sample : sh_ff;
      digit    = sh_src[DIGIT_W-1:0];
      prod     = cw_cur * $signed({1'b0, digit});
      acc_base = ctrl.clear_acc ? '0 : acc_ff;
      acc_in   = acc_base + ACC_W'(prod);
      cw_in    = cw_cur <<< DIGIT_W;
      sh_in    = sh_src >> DIGIT_W;
      adj      = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(ROUND_BIAS) : ACC_W'(0));
      q_in     = adj[ACC_W-1:FRAC_BITS];
   end

   always_comb begin
      if (q_ff > Q_MAX) begin
         result = OUT_MAX;
      end else if (q_ff < Q_MIN) begin
         result = OUT_MIN;
      end else begin
         result = OUT_W'(q_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
         cw_ff  <= cw_in;
         sh_ff  <= sh_in;
      end
      if (ctrl.round) begin
         q_ff <= q_in;
      end
   end

endmodule

// ===== rtl/core/block_fir_filter_zero_padded.sv =====
`timescale 1ns / 1ps
// Top level of the zero-padded block FIR filter for 12-bit ADC samples.
// Depends on fir_zp_pkg, fir_zp_mac and block_fir_filter_zero_padded_macros.svh.
//
// Usage. Items enter on the req_ channel with a valid/ready transfer. With
// req_op at its coefficient code an item writes req_coeff_value into tap
// req_coeff_index (an index at or above the tap count is ignored) and gives
// no result. Otherwise it carries one ADC sample; req_block_end marks the
// last sample of a block. Outputs leave on the rsp_ channel, rsp_last set on
// the final output of each block. Samples outside a block count as zero.
// A coefficient write ends at its transfer; a sample that gives no result is
// taken and then shifted into the window. Each output is summed tap by tap,
// one 4-bit digit at a time, in the shared multiply-accumulate unit, then
// rounded and handed over. A block end shifts in (DELAY - fill) zeros, fill
// counting that last sample, and then gives one output per sample held, so up
// to 17 outputs come from one item.
// Only one item is in work at a time; req_ready is high while idle.
// Reset clears the coefficients, the sample window and the block fill count.
// When the receiver stalls, a finished output waits in the output register;
// new items are still taken until the next output needs that register.
`include "block_fir_filter_zero_padded_macros.svh"
module block_fir_filter_zero_padded (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic [fir_zp_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                  req_block_end,
   input  logic [fir_zp_pkg::IDX_W-1:0]          req_coeff_index,
   input  logic signed [fir_zp_pkg::COEFF_W-1:0] req_coeff_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [fir_zp_pkg::OUT_W-1:0]   rsp_filtered,
   output logic                                  rsp_last
);
   import fir_zp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MAC   = 3'd1;
   localparam logic [2:0] S_RND   = 3'd2;
   localparam logic [2:0] S_OUT   = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_PAD   = 3'd5;

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DELAY);
   localparam logic [FILL_W-1:0] ONE       = FILL_W'(1);

   logic [2:0]                state_ff, state_in;
   logic signed [COEFF_W-1:0] coeff_ff [TAPS];
   logic signed [COEFF_W-1:0] coeff_in [TAPS];
   logic [SAMPLE_W-1:0]       win_ff [TAPS];
   logic [SAMPLE_W-1:0]       win_in [TAPS];
   logic [FILL_W-1:0]         fill_ff, fill_in, fill_inc;
   logic [FILL_W-1:0]         pad_ff, pad_in;
   logic [FILL_W-1:0]         fcnt_ff, fcnt_in;
   logic [TAP_W-1:0]          tap_ff, tap_in;
   logic [DIG_W-1:0]          dig_ff, dig_in;
   logic                      flush_ff, flush_in;
   logic                      bend_ff, bend_in;
   logic [SAMPLE_W-1:0]       sample_ff, sample_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]   rsp_filtered_ff, rsp_filtered_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_fire, out_free, last_dig, last_tap;
   logic                      win_shift, win_rot, win_clr;
   logic [SAMPLE_W-1:0]       shift_val;
   mac_ctrl_type              mac_ctrl;
   logic signed [OUT_W-1:0]   mac_result;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_last     = rsp_last_ff;

   assign last_dig = (dig_ff == DIG_W'(NUM_DIGITS - 1));
   assign last_tap = (tap_ff == TAP_W'(TAPS - 1));
   assign fill_inc = (fill_ff < FILL_FULL) ? fill_ff + ONE : fill_ff;

   // The window rotates by one place after each tap, so the unit always
   // reads the oldest-first entry at position zero and, after a full pass,
   // the window is back where it started.
   always_comb begin
      mac_ctrl.en        = (state_ff == S_MAC);
      mac_ctrl.load_tap  = (dig_ff == '0);
      mac_ctrl.clear_acc = (dig_ff == '0) && (tap_ff == '0);
      mac_ctrl.round     = (state_ff == S_RND);
   end

   fir_zp_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coeff  (coeff_ff[tap_ff]),
      .sample (win_ff[0]),
      .result (mac_result)
   );

   // Sequencer. A sample with a full fill first produces the output of the
   // current window, then shifts itself in. A block end pads the window
   // with zeros up to the delay and then produces one output per sample
   // held, shifting in one zero between outputs.
   always_comb begin
      state_in        = state_ff;
      coeff_in        = coeff_ff;
      fill_in         = fill_ff;
      pad_in          = pad_ff;
      fcnt_in         = fcnt_ff;
      tap_in          = tap_ff;
      dig_in          = dig_ff;
      flush_in        = flush_ff;
      bend_in         = bend_ff;
      sample_in       = sample_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in = rsp_filtered_ff;
      rsp_last_in     = rsp_last_ff;
      win_shift       = 1'b0;
      win_rot         = 1'b0;
      win_clr         = 1'b0;
      shift_val       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_COEFF) begin
                  if (req_coeff_index < IDX_W'(TAPS)) begin
                     coeff_in[req_coeff_index[TAP_W-1:0]] = req_coeff_value;
                  end
               end else begin
                  sample_in = req_sample;
                  bend_in   = req_block_end;
                  flush_in  = 1'b0;
                  state_in  = (fill_ff == FILL_FULL) ? S_MAC : S_SHIFT;
               end
            end
         end
         S_MAC: begin
            if (last_dig) begin
               dig_in  = '0;
               win_rot = 1'b1;
               if (last_tap) begin
                  tap_in   = '0;
                  state_in = S_RND;
               end else begin
                  tap_in = tap_ff + TAP_W'(1);
               end
            end else begin
               dig_in = dig_ff + DIG_W'(1);
            end
         end
         S_RND: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = mac_result;
               rsp_last_in     = flush_ff && (fcnt_ff == ONE);
               if (!flush_ff) begin
                  state_in = S_SHIFT;
               end else if (fcnt_ff == ONE) begin
                  win_clr  = 1'b1;
                  fill_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  fcnt_in   = fcnt_ff - ONE;
                  win_shift = 1'b1;
                  state_in  = S_MAC;
               end
            end
         end
         S_SHIFT: begin
            win_shift = 1'b1;
            shift_val = sample_ff;
            fill_in   = fill_inc;
            if (bend_ff) begin
               flush_in = 1'b1;
               fcnt_in  = fill_inc;
               pad_in   = FILL_FULL - fill_inc;
               state_in = (fill_inc == FILL_FULL) ? S_MAC : S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            win_shift = 1'b1;
            pad_in    = pad_ff - ONE;
            if (pad_ff == ONE) begin
               state_in = S_MAC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      win_in = win_ff;
      if (win_clr) begin
         for (int i = 0; i < TAPS; i++) begin
            win_in[i] = '0;
         end
      end else if (win_shift || win_rot) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[TAPS-1] = win_shift ? shift_val : win_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         tap_ff       <= '0;
         dig_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            coeff_ff[i] <= '0;
            win_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tap_ff       <= tap_in;
         dig_ff       <= dig_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
         coeff_ff     <= coeff_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff          <= pad_in;
      fcnt_ff         <= fcnt_in;
      bend_ff         <= bend_in;
      sample_ff       <= sample_in;
      rsp_filtered_ff <= rsp_filtered_in;
      rsp_last_ff     <= rsp_last_in;
   end

   `FZP_ASSERT_IMPL(a_fill_bounded, clock, reset, 1'b1, fill_ff <= FILL_FULL)
   `FZP_ASSERT_IMPL(a_pad_nonzero, clock, reset, state_ff == S_PAD, pad_ff != '0)
   `FZP_ASSERT_IMPL(a_flush_count, clock, reset, flush_ff && (state_ff == S_MAC), (fcnt_ff != '0) && (fcnt_ff <= FILL_FULL))
   `FZP_ASSERT_NEXT(a_block_closed, clock, reset, (state_ff == S_OUT) && out_free && flush_ff && (fcnt_ff == ONE), (fill_ff == '0) && (state_ff == S_IDLE) && rsp_last)

endmodule

// ===== tb/block_fir_filter_zero_padded_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the zero-padded block FIR filter: a queue-fed driver,
// a response monitor and an in-bench predictor of taps, sample window and block fill.
// Depends on fir_zp_pkg and the block_fir_filter_zero_padded RTL.
module block_fir_filter_zero_padded_test;
   import fir_zp_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 5000000;
   // Quiet tail after the last predicted output, so that a stray extra output is still seen.
   localparam int TAIL_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 200;
   localparam int IDLE_PERCENT = 12;
   localparam int MAX_INDEX    = 125;
   localparam int QUIET_FROM   = 4000;
   localparam int QUIET_TO     = 10000;
   localparam int HOLD_CYCLES  = 800;
   localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_MAG  = longint'(1) << (OUT_W - 1);

   // One item on the request channel.
   typedef struct {
      logic                      op;
      logic [SAMPLE_W-1:0]       sample;
      logic                      block_end;
      logic [IDX_W-1:0]          coeff_index;
      logic signed [COEFF_W-1:0] coeff_value;
   } fir_req_type;

   // One filter output on the response channel.
   typedef struct {
      logic signed [OUT_W-1:0] filtered;
      logic                    last;
   } fir_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = OP_SAMPLE;
   logic [SAMPLE_W-1:0]       req_sample = '0;
   logic                      req_block_end = 1'b0;
   logic [IDX_W-1:0]          req_coeff_index = '0;
   logic signed [COEFF_W-1:0] req_coeff_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]   rsp_filtered;
   logic                      rsp_last;

   // Items still to be offered, the item currently on the port, and the outputs
   // that the predictor says must still come out, oldest first.
   fir_req_type pending_reqs[$];
   fir_req_type in_flight;
   fir_rsp_type expected_outputs[$];

   // Predictor state: the coefficient taps, the sample window (oldest first) and
   // the count of samples seen in the current block, saturating at DELAY.
   logic signed [COEFF_W-1:0] tap_coeff [TAPS];
   logic [SAMPLE_W-1:0]       tap_window [TAPS];
   int unsigned               window_fill;

   int unsigned cycle_count = 0;
   int          hold_left = 0;
   bit          failed = 1'b0;
   logic        quiet_window;

   block_fir_filter_zero_padded DUT (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_op,
      .req_sample,
      .req_block_end,
      .req_coeff_index,
      .req_coeff_value,
      .rsp_valid,
      .rsp_ready,
      .rsp_filtered,
      .rsp_last
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Neither side idles inside this stretch, so the block sees back-to-back traffic.
   assign quiet_window = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

   // Multiply-accumulate over the whole window, then drop the Q1.15 fraction with
   // truncation toward zero and saturate to the signed output width.
   function automatic logic signed [OUT_W-1:0] fir_tap_sum();
      longint acc;
      longint q;
      acc = 0;
      for (int m = 0; m < TAPS; m++) begin
         acc += longint'(tap_coeff[m]) * longint'(tap_window[m]);
      end
      if (acc < 0) begin
         q = (-acc) >>> FRAC_BITS;
         if (q > OUT_MAG) begin
            q = OUT_MAG;
         end
         return OUT_W'(-q);
      end
      q = acc >>> FRAC_BITS;
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end
      return OUT_W'(q);
   endfunction

   function automatic void window_shift(input logic [SAMPLE_W-1:0] value);
      for (int m = 0; m < TAPS - 1; m++) begin
         tap_window[m] = tap_window[m + 1];
      end
      tap_window[TAPS - 1] = value;
   endfunction

   // Applies one accepted item to the predictor and queues the outputs it causes.
   function automatic void predict_filter(input fir_req_type r);
      fir_rsp_type o;
      int unsigned held;
      if (r.op == OP_COEFF) begin
         // Taps outside the table are silently dropped.
         if (r.coeff_index < TAPS) begin
            tap_coeff[r.coeff_index[TAP_W-1:0]] = r.coeff_value;
         end
         return;
      end
      // Once the window holds DELAY samples, every new sample pushes out one output.
      if (window_fill >= DELAY) begin
         o.filtered = fir_tap_sum();
         o.last     = 1'b0;
         expected_outputs.push_back(o);
      end
      window_shift(r.sample);
      if (window_fill < DELAY) begin
         window_fill++;
      end
      if (r.block_end) begin
         // Pad a short block with zeros up to the delay, then flush one output per
         // held sample, shifting in zeros between them.
         held = window_fill;
         for (int i = held; i < DELAY; i++) begin
            window_shift('0);
         end
         for (int i = 0; i < held; i++) begin
            if (i > 0) begin
               window_shift('0);
            end
            o.filtered = fir_tap_sum();
            o.last     = (i + 1 == held);
            expected_outputs.push_back(o);
         end
         for (int m = 0; m < TAPS; m++) begin
            tap_window[m] = '0;
         end
         window_fill = 0;
      end
   endfunction

   // Stimulus helpers. Fields that the operation ignores carry random values.
   function automatic void queue_sample(input int value, input bit bend);
      fir_req_type r;
      r.op          = OP_SAMPLE;
      r.sample      = SAMPLE_W'(value);
      r.block_end   = bend;
      r.coeff_index = IDX_W'($urandom_range(0, MAX_INDEX));
      r.coeff_value = COEFF_W'($urandom);
      pending_reqs.push_back(r);
   endfunction

   function automatic void queue_coeff(input int index, input int value);
      fir_req_type r;
      r.op          = OP_COEFF;
      r.sample      = SAMPLE_W'($urandom);
      r.block_end   = 1'($urandom_range(0, 1));
      r.coeff_index = IDX_W'(index);
      r.coeff_value = COEFF_W'(value);
      pending_reqs.push_back(r);
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return (1 << SAMPLE_W) - 1;
         default: return $urandom_range(0, (1 << SAMPLE_W) - 1);
      endcase
   endfunction

   // Mostly moderate taps so outputs land inside the range; sometimes any value.
   function automatic int rand_coeff();
      if ($urandom_range(0, 3) == 0) begin
         return int'($urandom_range(0, 65535)) - 32768;
      end
      return int'($urandom_range(0, 8191)) - 4096;
   endfunction

   function automatic int rand_index();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(TAPS, MAX_INDEX);
      end
      return $urandom_range(0, TAPS - 1);
   endfunction

   // Free-running cycle count and the overall watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL block_fir_filter_zero_padded");
         $finish;
      end
   end

   // Long receiver hold-offs. The sender keeps offering items during them, so the
   // finished output sits in the output register and the block stops taking input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_count == 1500 || cycle_count == 14000) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver side: random stalls outside the quiet stretch, and a full stall during a hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) &&
                      (quiet_window || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Driver. On a transfer the item goes through the predictor; then the next item
   // from the queue is put on the port, unless this cycle is a random gap.
   // req_valid gets exactly one nonblocking assignment per edge.
   always @(posedge clock) begin
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_filter(in_flight);
            offer = 1'b0;
         end
         if (!offer && pending_reqs.size() != 0 &&
             (quiet_window || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            in_flight = pending_reqs.pop_front();
            offer = 1'b1;
            req_op          <= in_flight.op;
            req_sample      <= in_flight.sample;
            req_block_end   <= in_flight.block_end;
            req_coeff_index <= in_flight.coeff_index;
            req_coeff_value <= in_flight.coeff_value;
         end
      end
      req_valid <= offer;
   end

   // Monitor. Every output transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      fir_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected output, expected none, got filtered=%0d last=%0b",
                     $time, rsp_filtered, rsp_last);
            failed = 1'b1;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_filtered !== want.filtered) begin
               $display("%0t: filtered mismatch, expected %0d, got %0d",
                        $time, want.filtered, rsp_filtered);
               failed = 1'b1;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last mismatch, expected %0b, got %0b",
                        $time, want.last, rsp_last);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      int blk;
      int len;
      int item_goal;
      int first_tap;

      // Predictor starts from the reset state of the block.
      for (int m = 0; m < TAPS; m++) begin
         tap_coeff[m]  = '0;
         tap_window[m] = '0;
      end
      window_fill = 0;

      // Directed part. A one-sample block with all taps at zero, then taps at the
      // extremes, writes past the end of the table that must be ignored, and a short
      // block with the extreme sample values and a tap write in its middle.
      queue_sample((1 << SAMPLE_W) - 1, 1'b1);
      queue_coeff(0, 32767);
      queue_coeff(TAPS - 1, -32768);
      queue_coeff(HALF_TAPS, 1);
      queue_coeff(TAPS, 12345);
      queue_coeff(MAX_INDEX, -1);
      queue_coeff(HALF_TAPS - 1, -2);
      queue_sample(0, 1'b0);
      queue_sample((1 << SAMPLE_W) - 1, 1'b0);
      queue_coeff(HALF_TAPS + 1, 16384);
      queue_sample((1 << SAMPLE_W) - 1, 1'b0);
      queue_sample(1, 1'b0);
      queue_sample(1 << (SAMPLE_W - 1), 1'b1);

      // Random part, one block at a time: a few tap writes, then a block of samples
      // that always closes with a block end. Two blocks drive ten taps to the
      // positive and then the negative limit with full-scale samples, so that the
      // output saturates both ways; those taps are scrambled again afterwards.
      item_goal = pending_reqs.size() + RANDOM_ITEMS;
      blk = 0;
      while (pending_reqs.size() < item_goal) begin
         if (blk == 3 || blk == 8) begin
            first_tap = HALF_TAPS;
            for (int t = 0; t < 10; t++) begin
               queue_coeff(first_tap + t, (blk == 3) ? 32767 : -32768);
            end
            len = DELAY + 2;
            for (int k = 0; k < len; k++) begin
               queue_sample((1 << SAMPLE_W) - 1, k == len - 1);
            end
            for (int t = 0; t < 10; t++) begin
               queue_coeff(first_tap + t, rand_coeff());
            end
         end else begin
            repeat ($urandom_range(0, 6)) begin
               queue_coeff(rand_index(), rand_coeff());
            end
            // Short blocks end inside the delay, boundary blocks right at it, long
            // blocks run past it, up to twice the window length.
            case ($urandom_range(0, 3))
               0:       len = $urandom_range(1, DELAY - 1);
               1:       len = $urandom_range(DELAY, DELAY + 1);
               default: len = $urandom_range(DELAY + 2, 2 * TAPS);
            endcase
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0) begin
                  queue_coeff(rand_index(), rand_coeff());
               end
               queue_sample(rand_sample(), k == len - 1);
            end
         end
         blk++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken, then for every predicted output. The checks
      // run at the falling edge, after the driver and monitor have settled.
      while (pending_reqs.size() != 0 || req_valid) @(negedge clock);
      while (expected_outputs.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (!failed) begin
         $display("PASS block_fir_filter_zero_padded");
      end else begin
         $display("FAIL block_fir_filter_zero_padded");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fir_zp_pkg.sv
rtl/core/fir_zp_mac.sv
rtl/core/block_fir_filter_zero_padded.sv
tb/block_fir_filter_zero_padded_test.sv
